// ----- hdl/flat_json_object_tokenizer_assert.svh -----
// Assertion macros for the flat JSON object tokenizer.
// Included by the top level; no other dependencies.
`ifndef FLAT_JSON_OBJECT_TOKENIZER_ASSERT_SVH
`define FLAT_JSON_OBJECT_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define FJOT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fjot assertion failed");
// Next-cycle implication, checked outside reset
`define FJOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fjot assertion failed");
`else
`define FJOT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define FJOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/fjot_pkg.sv -----
// Shared types and constants of the flat JSON object tokenizer.
// No dependencies; used by fjot_step and flat_json_object_tokenizer.
package fjot_pkg;

    // Parse phases
    localparam logic [3:0] PH_OPEN      = 4'd0;
    localparam logic [3:0] PH_KEY_CLOSE = 4'd1;
    localparam logic [3:0] PH_KEY       = 4'd2;
    localparam logic [3:0] PH_KEY_ESC   = 4'd3;
    localparam logic [3:0] PH_COLON     = 4'd4;
    localparam logic [3:0] PH_VALUE     = 4'd5;
    localparam logic [3:0] PH_SVAL      = 4'd6;
    localparam logic [3:0] PH_SVAL_ESC  = 4'd7;
    localparam logic [3:0] PH_PRIM      = 4'd8;
    localparam logic [3:0] PH_AFTER_VAL = 4'd9;
    localparam logic [3:0] PH_DONE      = 4'd10;

    // Token kinds
    localparam logic [2:0] K_KEY  = 3'd0;
    localparam logic [2:0] K_VAL  = 3'd1;
    localparam logic [2:0] K_PAIR = 3'd2;
    localparam logic [2:0] K_ACC  = 3'd3;
    localparam logic [2:0] K_ERR  = 3'd4;

    // Error codes
    localparam logic [2:0] E_NO_OBJECT = 3'd0;
    localparam logic [2:0] E_EARLY_END = 3'd1;
    localparam logic [2:0] E_BAD_KEY   = 3'd2;
    localparam logic [2:0] E_NO_COLON  = 3'd3;
    localparam logic [2:0] E_BAD_SVAL  = 3'd4;
    localparam logic [2:0] E_BAD_VALUE = 3'd5;
    localparam logic [2:0] E_NO_SEP    = 3'd6;
    localparam logic [2:0] E_NONE      = 3'd0;

    // Syntax characters
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // One result item
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic [2:0] err;
        logic       last;
    } t_result;

    // Outcome of one parse step
    typedef struct packed {
        logic [3:0] next_phase;
        logic [1:0] n;
        t_result    res0;
        t_result    res1;
    } t_step;

    function automatic logic is_ws(input logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CH_N) r = CH_LF;
        else if (c == CH_R) r = CH_CR;
        else if (c == CH_T) r = CH_TAB;
        return r;
    endfunction

    function automatic t_result mk_res(input logic [2:0] kind, input logic [7:0] ch,
                                       input logic [2:0] err);
        t_result r;
        r.kind = kind;
        r.ch   = ch;
        r.err  = err;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

// ----- hdl/flat_json_object_tokenizer.sv -----
// Top level of the flat JSON object tokenizer: input register, parse step, result queue.
// Depends on fjot_pkg, fjot_step and flat_json_object_tokenizer_assert.svh.
//
// Usage: body bytes enter on the slave stream, one byte per item; an item with
// tlast high carries no byte and ends the body. Results leave on the master
// stream: tuser is the token kind, tdata holds the decoded character and the
// error code, tlast flags the final result caused by one input item.
// Items with no result (whitespace, quotes, separators) produce nothing.
// Each accepted item is held in the input register and parsed from there; its
// results go into the result queue and are offered from its head on the master side.
// Throughput: one input item per cycle while the queue has room for two results.
// A four-entry result queue takes up to two results per item and drains one per
// cycle while the receiver is ready; the queue's free space sets tready.
// Reset clears the input register, the queue and the phase (waiting for the
// opening brace). When the receiver stalls, results wait in the queue and the
// input side stops once fewer than two queue entries are free.
`include "flat_json_object_tokenizer_assert.svh"

module flat_json_object_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // end_of_body
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] char_out, [10:8] err_code, rest zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] token_kind
    output logic        o_m_axis_tlast    // last_of_run
);

    // Queue fill levels
    localparam logic [fjot_pkg::FIFO_AW:0] CNT_FULL  =
        (fjot_pkg::FIFO_AW + 1)'(fjot_pkg::FIFO_DEPTH);
    localparam logic [fjot_pkg::FIFO_AW:0] CNT_ROOM2 =
        (fjot_pkg::FIFO_AW + 1)'(fjot_pkg::FIFO_DEPTH - 2);

    // Input register
    logic            r_in_valid;
    logic [7:0]      r_data;
    logic            r_end;
    // Parse phase
    logic [3:0]      r_phase;
    // Result queue
    fjot_pkg::t_result r_fifo [fjot_pkg::FIFO_DEPTH];
    logic [fjot_pkg::FIFO_AW-1:0] r_wr_ptr;
    logic [fjot_pkg::FIFO_AW-1:0] r_rd_ptr;
    logic [fjot_pkg::FIFO_AW:0]   r_count;
    logic [fjot_pkg::FIFO_AW:0]   n_count;

    fjot_pkg::t_step w_step;
    logic            w_proc;
    logic            w_pop;
    logic            w_push1;
    logic            w_push2;
    logic            w_in_acc;
    logic            w_done_item;
    fjot_pkg::t_result w_head;

    fjot_step u_step (
        .i_phase (r_phase),
        .i_data  (r_data),
        .i_end   (r_end),
        .o_step  (w_step)
    );

    // Parse when the queue can take two results
    assign w_proc   = r_in_valid && (r_count <= CNT_ROOM2);
    assign w_push1  = w_proc && (w_step.n != 2'd0);
    assign w_push2  = w_proc && (w_step.n == 2'd2);
    assign w_pop    = (r_count != '0) && i_m_axis_tready;
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = !r_in_valid || w_proc;

    // Byte parsed after the object is finished
    assign w_done_item = w_proc && !r_end && (r_phase == fjot_pkg::PH_DONE);

    // Hold the item until it is parsed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_data <= i_s_axis_tdata;
            r_end  <= i_s_axis_tlast;
        end
    end

    // Advance the phase on each parsed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fjot_pkg::PH_OPEN;
        end else if (w_proc) begin
            r_phase <= w_step.next_phase;
        end
    end

    // Queue fill count
    always_comb begin
        n_count = r_count;
        if (w_push1) n_count = n_count + 1'b1;
        if (w_push2) n_count = n_count + 1'b1;
        if (w_pop)   n_count = n_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_count <= n_count;
            if (w_push2) begin
                r_wr_ptr <= r_wr_ptr + 2'd2;
            end else if (w_push1) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Store results in order
    always_ff @(posedge i_clk) begin
        if (w_push1) begin
            r_fifo[r_wr_ptr] <= w_step.res0;
        end
        if (w_push2) begin
            r_fifo[r_wr_ptr + 1'b1] <= w_step.res1;
        end
    end

    // Present the queue head
    assign w_head          = r_fifo[r_rd_ptr];
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = {5'd0, w_head.err, w_head.ch};
    assign o_m_axis_tuser  = w_head.kind;
    assign o_m_axis_tlast  = w_head.last;

    // Checks
    `FJOT_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL)
    `FJOT_ASSERT_IMPLY(a_done_silent, i_clk, i_rst_n, w_done_item, w_step.n == 2'd0)
    `FJOT_ASSERT_NEXT(a_end_rearms, i_clk, i_rst_n, w_proc && r_end, r_phase == fjot_pkg::PH_OPEN)
    `FJOT_ASSERT_IMPLY(a_push2_room, i_clk, i_rst_n, w_push2, r_count <= CNT_ROOM2)

endmodule

// ----- hdl/fjot_step.sv -----
// One parse step of the tokenizer: phase and item in, next phase and results out.
// Depends on fjot_pkg.
module fjot_step (
    input  logic [3:0]     i_phase,
    input  logic [7:0]     i_data,
    input  logic           i_end,
    output fjot_pkg::t_step o_step
);

    fjot_pkg::t_step s;
    logic            ws;

    assign ws = fjot_pkg::is_ws(i_data);

    // Decode the phase against the current item
    always_comb begin
        s.next_phase = i_phase;
        s.n          = 2'd0;
        s.res0       = fjot_pkg::mk_res(fjot_pkg::K_KEY, 8'h00, fjot_pkg::E_NONE);
        s.res1       = fjot_pkg::mk_res(fjot_pkg::K_KEY, 8'h00, fjot_pkg::E_NONE);
        if (i_end) begin
            s.next_phase = fjot_pkg::PH_OPEN;
            s.n          = 2'd1;
            case (i_phase)
                fjot_pkg::PH_OPEN: begin
                    s.res0 = fjot_pkg::mk_res(fjot_pkg::K_ERR, 8'h00, fjot_pkg::E_NO_OBJECT);
                end
                fjot_pkg::PH_KEY_CLOSE, fjot_pkg::PH_AFTER_VAL: begin
                    s.res0 = fjot_pkg::mk_res(fjot_pkg::K_ERR, 8'h00, fjot_pkg::E_EARLY_END);
                end
                fjot_pkg::PH_KEY, fjot_pkg::PH_KEY_ESC: begin
                    s.res0 = fjot_pkg::mk_res(fjot_pkg::K_ERR, 8'h00, fjot_pkg::E_BAD_KEY);
                end
                fjot_pkg::PH_COLON: begin
                    s.res0 = fjot_pkg::mk_res(fjot_pkg::K_ERR, 8'h00, fjot_pkg::E_NO_COLON);
                end
                fjot_pkg::PH_VALUE: begin
                    s.res0 = fjot_pkg::mk_res(fjot_pkg::K_ERR, 8'h00, fjot_pkg::E_BAD_VALUE);
                end
                fjot_pkg::PH_SVAL, fjot_pkg::PH_SVAL_ESC: begin
                    s.res0 = fjot_pkg::mk_res(fjot_pkg::K_ERR, 8'h00, fjot_pkg::E_BAD_SVAL);
                end
                fjot_pkg::PH_PRIM: begin
                    // primitive cut short: close the pair, then report
                    s.n    = 2'd2;
                    s.res0 = fjot_pkg::mk_res(fjot_pkg::K_PAIR, 8'h00, fjot_pkg::E_NONE);
                    s.res1 = fjot_pkg::mk_res(fjot_pkg::K_ERR, 8'h00, fjot_pkg::E_EARLY_END);
                end
                default: begin
                    s.n = 2'd0;
                end
            endcase
        end else begin
            case (i_phase)
                fjot_pkg::PH_OPEN: begin
                    if (!ws) begin
                        if (i_data == fjot_pkg::CH_LBRACE) begin
                            s.next_phase = fjot_pkg::PH_KEY_CLOSE;
                        end else begin
                            s.n          = 2'd1;
                            s.res0       = fjot_pkg::mk_res(fjot_pkg::K_ERR, 8'h00,
                                                            fjot_pkg::E_NO_OBJECT);
                            s.next_phase = fjot_pkg::PH_DONE;
                        end
                    end
                end
                fjot_pkg::PH_KEY_CLOSE: begin
                    if (!ws) begin
                        if (i_data == fjot_pkg::CH_RBRACE) begin
                            s.n          = 2'd1;
                            s.res0       = fjot_pkg::mk_res(fjot_pkg::K_ACC, 8'h00,
                                                            fjot_pkg::E_NONE);
                            s.next_phase = fjot_pkg::PH_DONE;
                        end else if (i_data == fjot_pkg::CH_QUOTE) begin
                            s.next_phase = fjot_pkg::PH_KEY;
                        end else begin
                            s.n          = 2'd1;
                            s.res0       = fjot_pkg::mk_res(fjot_pkg::K_ERR, 8'h00,
                                                            fjot_pkg::E_BAD_KEY);
                            s.next_phase = fjot_pkg::PH_DONE;
                        end
                    end
                end
                fjot_pkg::PH_KEY: begin
                    if (i_data == fjot_pkg::CH_BSLASH) begin
                        s.next_phase = fjot_pkg::PH_KEY_ESC;
                    end else if (i_data == fjot_pkg::CH_QUOTE) begin
                        s.next_phase = fjot_pkg::PH_COLON;
                    end else begin
                        s.n    = 2'd1;
                        s.res0 = fjot_pkg::mk_res(fjot_pkg::K_KEY, i_data, fjot_pkg::E_NONE);
                    end
                end
                fjot_pkg::PH_KEY_ESC: begin
                    s.n          = 2'd1;
                    s.res0       = fjot_pkg::mk_res(fjot_pkg::K_KEY, fjot_pkg::unescape(i_data),
                                                    fjot_pkg::E_NONE);
                    s.next_phase = fjot_pkg::PH_KEY;
                end
                fjot_pkg::PH_COLON: begin
                    if (!ws) begin
                        if (i_data == fjot_pkg::CH_COLON) begin
                            s.next_phase = fjot_pkg::PH_VALUE;
                        end else begin
                            s.n          = 2'd1;
                            s.res0       = fjot_pkg::mk_res(fjot_pkg::K_ERR, 8'h00,
                                                            fjot_pkg::E_NO_COLON);
                            s.next_phase = fjot_pkg::PH_DONE;
                        end
                    end
                end
                fjot_pkg::PH_VALUE: begin
                    if (!ws) begin
                        if (i_data == fjot_pkg::CH_QUOTE) begin
                            s.next_phase = fjot_pkg::PH_SVAL;
                        end else if ((i_data == fjot_pkg::CH_COMMA) ||
                                     (i_data == fjot_pkg::CH_RBRACE)) begin
                            s.n          = 2'd1;
                            s.res0       = fjot_pkg::mk_res(fjot_pkg::K_ERR, 8'h00,
                                                            fjot_pkg::E_BAD_VALUE);
                            s.next_phase = fjot_pkg::PH_DONE;
                        end else begin
                            s.n          = 2'd1;
                            s.res0       = fjot_pkg::mk_res(fjot_pkg::K_VAL, i_data,
                                                            fjot_pkg::E_NONE);
                            s.next_phase = fjot_pkg::PH_PRIM;
                        end
                    end
                end
                fjot_pkg::PH_SVAL: begin
                    if (i_data == fjot_pkg::CH_BSLASH) begin
                        s.next_phase = fjot_pkg::PH_SVAL_ESC;
                    end else if (i_data == fjot_pkg::CH_QUOTE) begin
                        s.n          = 2'd1;
                        s.res0       = fjot_pkg::mk_res(fjot_pkg::K_PAIR, 8'h00,
                                                        fjot_pkg::E_NONE);
                        s.next_phase = fjot_pkg::PH_AFTER_VAL;
                    end else begin
                        s.n    = 2'd1;
                        s.res0 = fjot_pkg::mk_res(fjot_pkg::K_VAL, i_data, fjot_pkg::E_NONE);
                    end
                end
                fjot_pkg::PH_SVAL_ESC: begin
                    s.n          = 2'd1;
                    s.res0       = fjot_pkg::mk_res(fjot_pkg::K_VAL, fjot_pkg::unescape(i_data),
                                                    fjot_pkg::E_NONE);
                    s.next_phase = fjot_pkg::PH_SVAL;
                end
                fjot_pkg::PH_PRIM: begin
                    if (ws) begin
                        s.n          = 2'd1;
                        s.res0       = fjot_pkg::mk_res(fjot_pkg::K_PAIR, 8'h00,
                                                        fjot_pkg::E_NONE);
                        s.next_phase = fjot_pkg::PH_AFTER_VAL;
                    end else if (i_data == fjot_pkg::CH_COMMA) begin
                        s.n          = 2'd1;
                        s.res0       = fjot_pkg::mk_res(fjot_pkg::K_PAIR, 8'h00,
                                                        fjot_pkg::E_NONE);
                        s.next_phase = fjot_pkg::PH_KEY_CLOSE;
                    end else if (i_data == fjot_pkg::CH_RBRACE) begin
                        // brace closes the primitive and the object at once
                        s.n          = 2'd2;
                        s.res0       = fjot_pkg::mk_res(fjot_pkg::K_PAIR, 8'h00,
                                                        fjot_pkg::E_NONE);
                        s.res1       = fjot_pkg::mk_res(fjot_pkg::K_ACC, 8'h00,
                                                        fjot_pkg::E_NONE);
                        s.next_phase = fjot_pkg::PH_DONE;
                    end else begin
                        s.n    = 2'd1;
                        s.res0 = fjot_pkg::mk_res(fjot_pkg::K_VAL, i_data, fjot_pkg::E_NONE);
                    end
                end
                fjot_pkg::PH_AFTER_VAL: begin
                    if (!ws) begin
                        if (i_data == fjot_pkg::CH_COMMA) begin
                            s.next_phase = fjot_pkg::PH_KEY_CLOSE;
                        end else if (i_data == fjot_pkg::CH_RBRACE) begin
                            s.n          = 2'd1;
                            s.res0       = fjot_pkg::mk_res(fjot_pkg::K_ACC, 8'h00,
                                                            fjot_pkg::E_NONE);
                            s.next_phase = fjot_pkg::PH_DONE;
                        end else begin
                            s.n          = 2'd1;
                            s.res0       = fjot_pkg::mk_res(fjot_pkg::K_ERR, 8'h00,
                                                            fjot_pkg::E_NO_SEP);
                            s.next_phase = fjot_pkg::PH_DONE;
                        end
                    end
                end
                default: begin
                    s.next_phase = fjot_pkg::PH_DONE;
                end
            endcase
        end
        // Mark the final result of this item
        if (s.n == 2'd1) s.res0.last = 1'b1;
        if (s.n == 2'd2) s.res1.last = 1'b1;
    end

    assign o_step = s;

endmodule
